// File: rtl/core/dlfm_pkg.sv
// Shared constants, codes and types of the demoted list flood merge block.
package dlfm_pkg;

	localparam int LIST_LEN = 32;
	localparam int ID_BITS  = 16;
	localparam int IDX_W    = (LIST_LEN > 1) ? $clog2(LIST_LEN) : 1;
	localparam int CNT_W    = $clog2(LIST_LEN + 1);

	localparam logic [15:0] FAIL_MAX = 16'hFFFF;
	localparam logic [7:0]  DEMOTE_LIMIT_RST = 8'd4;

	typedef enum logic [2:0] {
		CMD_BEGIN = 3'd0,
		CMD_START = 3'd1,
		CMD_ELEM  = 3'd2,
		CMD_FAIL  = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_OWN_ID    = 2'd0,
		CFG_INITIATOR = 2'd1,
		CFG_LIMIT     = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_RD,
		S_CMP,
		S_ADD,
		S_FIN
	} state_t;

endpackage

// File: rtl/core/demote_list_flood_merge.sv
// Demoted node list merge: command sequencer, id store and serial duplicate search.
//
//   channel  | signals                                          | handshake
//   ---------+--------------------------------------------------+---------------------------
//   request  | command rx_node_id rx_size last cluster_head     | start & !busy
//            | joined_count new_threshold read_index            |
//   result   | transmit list_count entry_id entry_valid         | done, one cycle, no stall
//            | self_demoted                                     |
//   config   | cfg_index cfg_wdata                              | cfg_we, taken at once
//
// Commands that need no list search pass from accept through setup and finish back to idle.
// Round begin and received elements search the list through the single memory read
// port and one comparator: each stored entry scanned is read and then compared, and
// each insert attempt ends in an add step; one attempt for round begin, up to two for a
// last element. Reset clears all control state; the id store needs no clearing, entries
// past the count are never read. Results cannot be held off; codes 5 to 7 give no result.
module demote_list_flood_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          command,
	input  logic [15:0]         rx_node_id,
	input  logic [5:0]          rx_size,
	input  logic                last,
	input  logic                cluster_head,
	input  logic [7:0]          joined_count,
	input  logic [15:0]         new_threshold,
	input  logic [4:0]          read_index,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_wdata,
	output logic                done,
	output logic                transmit,
	output logic [5:0]          list_count,
	output logic [15:0]         entry_id,
	output logic                entry_valid,
	output logic                self_demoted
);

	dlfm_pkg::state_t state_q, state_d;

	// configuration
	logic [15:0] own_q;
	logic        init_q;
	logic [7:0]  limit_q;

	// latched request
	logic [2:0]                   cmd_q;
	logic [dlfm_pkg::ID_BITS-1:0] rx_id_q;
	logic [5:0]                   rx_size_q;
	logic                         last_q;
	logic                         head_q;
	logic [7:0]                   joined_q;
	logic [15:0]                  thresh_q;
	logic [4:0]                   ridx_q;

	// list state
	logic [dlfm_pkg::CNT_W-1:0] count_q;
	logic                       demoted_q;
	logic                       valid_seen_q;
	logic [15:0]                fail_q;
	logic [15:0]                restart_q;
	logic                       changed_q;
	logic                       in_list_q;

	// search unit
	logic [dlfm_pkg::ID_BITS-1:0] mem [dlfm_pkg::LIST_LEN];
	logic [dlfm_pkg::ID_BITS-1:0] rdata_q;
	logic [dlfm_pkg::ID_BITS-1:0] tgt_q;
	logic [dlfm_pkg::CNT_W-1:0]   k_q;
	logic                         hit_q;
	logic                         own_pend_q;
	logic                         tx_q;
	logic                         evalid_q;

	// outputs
	logic        done_q;
	logic        out_tx_q;
	logic [5:0]  out_count_q;
	logic [15:0] out_eid_q;
	logic        out_evalid_q;
	logic        out_dem_q;

	logic                         mem_we;
	logic                         mem_re;
	logic [dlfm_pkg::IDX_W-1:0]   rd_addr;

	logic                         demote_cond;
	logic                         ridx_ok;
	logic                         scan_end;
	logic                         hit;
	logic                         add_ok;
	logic                         size_differs;
	logic [15:0]                  fail_inc;
	logic                         restart_hit;
	logic [dlfm_pkg::ID_BITS-1:0] own_id;

	assign own_id       = own_q[dlfm_pkg::ID_BITS-1:0];
	assign demote_cond  = head_q && (joined_q < limit_q);
	assign ridx_ok      = 32'(ridx_q) < 32'(count_q);
	assign scan_end     = k_q >= count_q;
	assign hit          = rdata_q == tgt_q;
	assign add_ok       = !hit_q && (count_q < dlfm_pkg::CNT_W'(dlfm_pkg::LIST_LEN));
	assign size_differs = 32'(rx_size_q) != 32'(count_q);
	assign fail_inc     = (fail_q != dlfm_pkg::FAIL_MAX) ? fail_q + 16'd1 : fail_q;
	assign restart_hit  = (fail_inc > restart_q) && valid_seen_q;

	assign busy         = state_q != dlfm_pkg::S_IDLE;
	assign done         = done_q;
	assign transmit     = out_tx_q;
	assign list_count   = out_count_q;
	assign entry_id     = out_eid_q;
	assign entry_valid  = out_evalid_q;
	assign self_demoted = out_dem_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dlfm_pkg::S_IDLE: begin
				if (start) begin
					state_d = dlfm_pkg::S_SETUP;
				end
			end
			dlfm_pkg::S_SETUP: begin
				case (cmd_q)
					dlfm_pkg::CMD_BEGIN: begin
						state_d = demote_cond ? dlfm_pkg::S_RD : dlfm_pkg::S_FIN;
					end
					dlfm_pkg::CMD_ELEM: begin
						if (rx_size_q != 6'd0 || (last_q && demoted_q)) begin
							state_d = dlfm_pkg::S_RD;
						end else begin
							state_d = dlfm_pkg::S_FIN;
						end
					end
					dlfm_pkg::CMD_START, dlfm_pkg::CMD_FAIL, dlfm_pkg::CMD_READ: begin
						state_d = dlfm_pkg::S_FIN;
					end
					default: state_d = dlfm_pkg::S_IDLE;
				endcase
			end
			dlfm_pkg::S_RD: state_d = scan_end ? dlfm_pkg::S_ADD : dlfm_pkg::S_CMP;
			dlfm_pkg::S_CMP: state_d = hit ? dlfm_pkg::S_ADD : dlfm_pkg::S_RD;
			dlfm_pkg::S_ADD: state_d = own_pend_q ? dlfm_pkg::S_RD : dlfm_pkg::S_FIN;
			dlfm_pkg::S_FIN: state_d = dlfm_pkg::S_IDLE;
			default: state_d = dlfm_pkg::S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		rd_addr = k_q[dlfm_pkg::IDX_W-1:0];
		case (state_q)
			dlfm_pkg::S_SETUP: begin
				if (cmd_q == dlfm_pkg::CMD_READ && ridx_ok) begin
					mem_re  = 1'b1;
					rd_addr = dlfm_pkg::IDX_W'(ridx_q);
				end
			end
			dlfm_pkg::S_RD:  mem_re = !scan_end;
			dlfm_pkg::S_ADD: mem_we = add_ok;
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[dlfm_pkg::IDX_W-1:0]] <= tgt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// request latch and search target
	always_ff @(posedge clk) begin
		if (state_q == dlfm_pkg::S_IDLE && start) begin
			cmd_q     <= command;
			rx_id_q   <= rx_node_id[dlfm_pkg::ID_BITS-1:0];
			rx_size_q <= rx_size;
			last_q    <= last;
			head_q    <= cluster_head;
			joined_q  <= joined_count;
			thresh_q  <= new_threshold;
			ridx_q    <= read_index;
		end
		if (state_q == dlfm_pkg::S_SETUP) begin
			tgt_q <= (cmd_q == dlfm_pkg::CMD_ELEM && rx_size_q != 6'd0) ? rx_id_q : own_id;
		end else if (state_q == dlfm_pkg::S_ADD) begin
			tgt_q <= own_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dlfm_pkg::S_IDLE;
			own_q        <= '0;
			init_q       <= 1'b0;
			limit_q      <= dlfm_pkg::DEMOTE_LIMIT_RST;
			count_q      <= '0;
			demoted_q    <= 1'b0;
			valid_seen_q <= 1'b0;
			fail_q       <= '0;
			restart_q    <= '0;
			changed_q    <= 1'b0;
			in_list_q    <= 1'b0;
			k_q          <= '0;
			hit_q        <= 1'b0;
			own_pend_q   <= 1'b0;
			tx_q         <= 1'b0;
			evalid_q     <= 1'b0;
			done_q       <= 1'b0;
			out_tx_q     <= 1'b0;
			out_count_q  <= '0;
			out_eid_q    <= '0;
			out_evalid_q <= 1'b0;
			out_dem_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					dlfm_pkg::CFG_OWN_ID:    own_q   <= cfg_wdata;
					dlfm_pkg::CFG_INITIATOR: init_q  <= cfg_wdata[0];
					dlfm_pkg::CFG_LIMIT:     limit_q <= cfg_wdata[7:0];
					default: begin
						own_q <= own_q;
					end
				endcase
			end

			case (state_q)
				dlfm_pkg::S_SETUP: begin
					tx_q       <= 1'b0;
					evalid_q   <= 1'b0;
					k_q        <= '0;
					hit_q      <= 1'b0;
					own_pend_q <= 1'b0;
					case (cmd_q)
						dlfm_pkg::CMD_BEGIN: begin
							valid_seen_q <= 1'b0;
							fail_q       <= '0;
							restart_q    <= thresh_q;
							changed_q    <= 1'b0;
							in_list_q    <= 1'b0;
							demoted_q    <= demote_cond;
						end
						dlfm_pkg::CMD_START: begin
							if (init_q) begin
								valid_seen_q <= 1'b1;
								tx_q         <= 1'b1;
							end
						end
						dlfm_pkg::CMD_ELEM: begin
							valid_seen_q <= 1'b1;
							fail_q       <= '0;
							if (!in_list_q) begin
								in_list_q <= 1'b1;
								if (size_differs) begin
									changed_q <= 1'b1;
								end
							end
							// own id follows the received id when both go in
							own_pend_q <= rx_size_q != 6'd0 && last_q && demoted_q;
						end
						dlfm_pkg::CMD_FAIL: begin
							if (restart_hit) begin
								fail_q    <= '0;
								restart_q <= thresh_q;
								tx_q      <= 1'b1;
							end else begin
								fail_q <= fail_inc;
							end
						end
						dlfm_pkg::CMD_READ: evalid_q <= ridx_ok;
						default: begin
							tx_q <= 1'b0;
						end
					endcase
				end
				dlfm_pkg::S_CMP: begin
					if (hit) begin
						hit_q <= 1'b1;
					end else begin
						k_q <= k_q + dlfm_pkg::CNT_W'(1);
					end
				end
				dlfm_pkg::S_ADD: begin
					if (add_ok) begin
						count_q <= count_q + dlfm_pkg::CNT_W'(1);
						if (cmd_q == dlfm_pkg::CMD_ELEM) begin
							changed_q <= 1'b1;
						end
					end
					// restart the scan for the own id
					k_q        <= '0;
					hit_q      <= 1'b0;
					own_pend_q <= 1'b0;
				end
				dlfm_pkg::S_FIN: begin
					done_q       <= 1'b1;
					out_count_q  <= 6'(count_q);
					out_evalid_q <= evalid_q;
					out_eid_q    <= evalid_q ? 16'(rdata_q) : 16'd0;
					out_dem_q    <= demoted_q;
					if (cmd_q == dlfm_pkg::CMD_ELEM) begin
						out_tx_q <= last_q && changed_q;
						if (last_q) begin
							changed_q <= 1'b0;
							in_list_q <= 1'b0;
						end
					end else begin
						out_tx_q <= tx_q;
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == dlfm_pkg::S_FIN))
		else $error("result strobe without a finishing step");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dlfm_pkg::CNT_W'(dlfm_pkg::LIST_LEN))
		else $error("list count past capacity");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dlfm_pkg::S_CMP |-> k_q < count_q)
		else $error("compare on an entry past the count");

	a_valid_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		done && entry_valid |-> cmd_q == dlfm_pkg::CMD_READ)
		else $error("entry marked valid outside a read");

endmodule
